/* rtl/urd_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package urd_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} state_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic load;
		logic step;
		logic capture;
	} cmd_t;

endpackage
`default_nettype wire

/* rtl/urd_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
module urd_ctrl #(
	parameter int WIDTH = 32
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           in_valid,
	output logic          in_stall,
	output logic          out_valid,
	input  wire           out_stall,
	output urd_pkg::cmd_t cmd
);

	localparam int CW = (WIDTH > 2) ? $clog2(WIDTH) : 1;

	urd_pkg::state_t state_q, state_d;
	logic [CW-1:0]   cnt_q;
	logic            out_valid_q;
	logic            out_free;
	logic            last;

	assign out_free  = !out_valid_q || !out_stall;
	assign last      = (cnt_q == '0);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			urd_pkg::ST_IDLE: begin
				if (in_valid) state_d = urd_pkg::ST_RUN;
			end
			urd_pkg::ST_RUN: begin
				if (last) state_d = out_free ? urd_pkg::ST_IDLE : urd_pkg::ST_HOLD;
			end
			urd_pkg::ST_HOLD: begin
				if (out_free) state_d = urd_pkg::ST_IDLE;
			end
			default: state_d = urd_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		in_stall    = 1'b1;
		cmd.load    = 1'b0;
		cmd.step    = 1'b0;
		cmd.capture = 1'b0;
		unique case (state_q)
			urd_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			urd_pkg::ST_RUN: begin
				cmd.step    = 1'b1;
				cmd.capture = last && out_free;
			end
			urd_pkg::ST_HOLD: begin
				cmd.capture = out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= urd_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load) cnt_q <= CW'(WIDTH - 1);
			else if (cmd.step && !last) cnt_q <= cnt_q - CW'(1);
			// a new result wins over the item being taken
			if (cmd.capture) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> state_q == urd_pkg::ST_RUN && cnt_q == CW'(WIDTH - 1))
		else $error("accepted item did not start a full run");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.capture |-> !out_valid_q || !out_stall)
		else $error("result overwritten while waiting");

	a_hold_has_result: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == urd_pkg::ST_HOLD |-> out_valid_q)
		else $error("holding without a pending result");

	a_one_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.load && cmd.step))
		else $error("load and step together");

endmodule
`default_nettype wire

/* rtl/urd_dpath.sv */
`timescale 1ns / 1ps
`default_nettype none
module urd_dpath #(
	parameter int WIDTH = 32
) (
	input  wire              clk,
	input  urd_pkg::cmd_t    cmd,
	input  wire  [WIDTH-1:0] dividend,
	input  wire  [WIDTH-1:0] divisor,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output logic             divide_by_zero
);

	logic [WIDTH-1:0] part_q, quo_q, dvs_q;
	logic             dbz_q;
	logic [WIDTH:0]   shifted;
	logic [WIDTH+1:0] diff;
	logic             fits;
	logic [WIDTH-1:0] part_next, quo_next;
	logic [WIDTH-1:0] part_sel, quo_sel;

	// quo_q starts as the dividend and takes quotient bits in at the bottom
	assign shifted   = {part_q, quo_q[WIDTH-1]};
	assign diff      = {1'b0, shifted} - {2'b00, dvs_q};
	assign fits      = !diff[WIDTH+1];
	assign part_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
	assign quo_next  = {quo_q[WIDTH-2:0], fits};
	assign part_sel  = cmd.step ? part_next : part_q;
	assign quo_sel   = cmd.step ? quo_next : quo_q;

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			part_q <= '0;
			quo_q  <= dividend;
			dvs_q  <= divisor;
			dbz_q  <= (divisor == '0);
		end else if (cmd.step) begin
			part_q <= part_next;
			quo_q  <= quo_next;
		end
		if (cmd.capture) begin
			quotient       <= dbz_q ? '0 : quo_sel;
			remainder      <= dbz_q ? '0 : part_sel;
			divide_by_zero <= dbz_q;
		end
	end

endmodule
`default_nettype wire

/* rtl/unsigned_restoring_divider_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// Unsigned radix-2 restoring divider: quotient and remainder of dividend / divisor,
// with divide_by_zero set and both results zero when the divisor is zero. An item first
// loads the operands, then takes one quotient bit per cycle from a single shared
// subtractor over WIDTH iterations. The result sits in an output register, so the
// next item is taken as soon as the iteration loop is free, even while the previous
// result is stalled.
module unsigned_restoring_divider_top #(
	parameter int WIDTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_stall,
	input  wire  [WIDTH-1:0] dividend,
	input  wire  [WIDTH-1:0] divisor,
	output logic             out_valid,
	input  wire              out_stall,
	output logic [WIDTH-1:0] quotient,
	output logic [WIDTH-1:0] remainder,
	output logic             divide_by_zero
);

	urd_pkg::cmd_t cmd;

	urd_ctrl #(.WIDTH(WIDTH)) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.cmd       (cmd)
	);

	urd_dpath #(.WIDTH(WIDTH)) u_dpath (
		.clk            (clk),
		.cmd            (cmd),
		.dividend       (dividend),
		.divisor        (divisor),
		.quotient       (quotient),
		.remainder      (remainder),
		.divide_by_zero (divide_by_zero)
	);

endmodule
`default_nettype wire
